FILE: hdl/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// Shared types and constants for the trade candle aggregator.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned MaxFill = 63;
  localparam int unsigned FillW   = 6;
  localparam logic [31:0] IntervalReset = 32'd1000;

  // One classified trade as passed from the front part to the back part.
  typedef struct packed {
    logic [47:0] idx;
    logic [31:0] price;
    logic [63:0] vol;
    logic        sell;
  } trade_item_t;

  typedef struct packed {
    logic [48:0] bar_end_time;
    logic [31:0] bar_high;
    logic [31:0] bar_avg;
    logic [31:0] bar_low;
    logic [63:0] buy_volume;
    logic [63:0] sell_volume;
    logic [31:0] buy_trades;
    logic [31:0] sell_trades;
    logic        is_gap_bar;
    logic        gap_truncated;
    logic        last_of_run;
  } bar_item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == {32{1'b1}}) ? a : a + 32'd1;
  endfunction

endpackage

FILE: hdl/tca_channels.sv
// ----------------------------------------------------------------------------
// tca channels
// Valid/ready channel interfaces for trades, bars and the interval register.
// ----------------------------------------------------------------------------
interface tca_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] trade_time;
  logic [31:0] trade_price;
  logic [31:0] trade_qty;
  logic        sell_side;
  modport source (output valid, trade_time, trade_price, trade_qty, sell_side,
                  input ready);
  modport sink (input valid, trade_time, trade_price, trade_qty, sell_side,
                output ready);
endinterface

interface tca_out_if;
  logic        valid;
  logic        ready;
  logic [48:0] bar_end_time;
  logic [31:0] bar_high;
  logic [31:0] bar_avg;
  logic [31:0] bar_low;
  logic [63:0] buy_volume;
  logic [63:0] sell_volume;
  logic [31:0] buy_trades;
  logic [31:0] sell_trades;
  logic        is_gap_bar;
  logic        gap_truncated;
  logic        last_of_run;
  modport source (output valid, bar_end_time, bar_high, bar_avg, bar_low, buy_volume,
                  sell_volume, buy_trades, sell_trades, is_gap_bar, gap_truncated,
                  last_of_run, input ready);
  modport sink (input valid, bar_end_time, bar_high, bar_avg, bar_low, buy_volume,
                sell_volume, buy_trades, sell_trades, is_gap_bar, gap_truncated,
                last_of_run, output ready);
endinterface

interface tca_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] bar_interval;
  modport source (output valid, bar_interval, input ready);
  modport sink (input valid, bar_interval, output ready);
endinterface

FILE: hdl/tca_div.sv
// ----------------------------------------------------------------------------
// tca_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module tca_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import tca_pkg::*;

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [32:0] rem_r;
  logic [63:0] quo_r;
  logic [32:0] div_r;
  logic [33:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[63]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? 33'(trial - {1'b0, div_r}) : trial[32:0];
      quo_r <= {quo_r[62:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/tca_front.sv
// ----------------------------------------------------------------------------
// tca_front
// Accepts trades, finds the bar index and the trade volume.
// ----------------------------------------------------------------------------
module tca_front (
  input  logic                 clk,
  input  logic                 rst_n,
  tca_in_if.sink               in_ch,
  input  logic [31:0]          iv,
  input  tca_pkg::q_status_t   q_stat,
  output logic                 push,
  output tca_pkg::trade_item_t push_item
);
  import tca_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t     st_r;
  logic [31:0] price_r;
  logic [63:0] vol_r;
  logic        sell_r;
  logic [47:0] idx_r;
  logic        accept;
  logic        div_done;
  logic [63:0] div_q;

  assign in_ch.ready = (st_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  tca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend ({16'b0, in_ch.trade_time}),
    .divisor  ({1'b0, iv}),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: if (accept) st_r <= F_DIV;
        F_DIV:  if (div_done) st_r <= F_PUSH;
        F_PUSH: if (!q_stat.full) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      price_r <= in_ch.trade_price;
      sell_r  <= in_ch.sell_side;
      vol_r   <= {32'b0, in_ch.trade_qty} * {32'b0, in_ch.trade_price};
    end
    if (st_r == F_DIV && div_done) begin
      idx_r <= div_q[47:0];
    end
  end

  assign push      = (st_r == F_PUSH) && !q_stat.full;
  assign push_item = '{idx: idx_r, price: price_r, vol: vol_r, sell: sell_r};

endmodule

FILE: hdl/tca_queue.sv
// ----------------------------------------------------------------------------
// tca_queue
// Two-entry queue of classified trades between the front and back parts.
// ----------------------------------------------------------------------------
module tca_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tca_pkg::trade_item_t push_item,
  input  logic                 pop,
  output tca_pkg::trade_item_t head,
  output tca_pkg::q_status_t   stat
);
  import tca_pkg::*;

  trade_item_t mem_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  assign head       = mem_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

FILE: hdl/tca_back.sv
// ----------------------------------------------------------------------------
// tca_back
// Holds the open bar, merges trades and emits closed and gap bars.
// ----------------------------------------------------------------------------
module tca_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tca_pkg::trade_item_t head,
  input  tca_pkg::q_status_t   q_stat,
  output logic                 pop,
  input  logic [31:0]          iv,
  tca_out_if.source            out_ch
);
  import tca_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL0, B_MUL1, B_SUM, B_DIV, B_CLOSE, B_GAP
  } bstate_t;

  bstate_t     st_r;
  logic        bar_open_r;
  logic [47:0] bar_index_r;
  logic [31:0] run_high_r;
  logic [31:0] run_low_r;
  logic [63:0] price_sum_r;
  logic [63:0] buy_vol_r;
  logic [63:0] sell_vol_r;
  logic [31:0] buy_cnt_r;
  logic [31:0] sell_cnt_r;
  trade_item_t cur_r;
  logic [FillW-1:0] fill_r;
  logic [FillW-1:0] gap_k_r;
  logic        trunc_r;
  logic [63:0] p0_r;
  logic [48:0] p1_r;
  logic [48:0] end_r;
  logic [31:0] avg_r;
  logic        out_valid_r;
  bar_item_t   out_r;

  logic [48:0] idx1;
  logic [47:0] gaps;
  logic        out_free;
  logic        emit;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_q;
  logic [32:0] cnt_sum;
  logic        do_start;
  logic        do_merge;
  logic        last_gap;

  assign idx1     = {1'b0, bar_index_r} + 49'd1;
  assign gaps     = head.idx - bar_index_r - 48'd1;
  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = ((st_r == B_CLOSE) || (st_r == B_GAP)) && out_free;
  assign cnt_sum  = {1'b0, buy_cnt_r} + {1'b0, sell_cnt_r};
  assign pop      = (st_r == B_IDLE) && !q_stat.empty;
  assign do_merge = pop && bar_open_r && (head.idx <= bar_index_r);
  assign last_gap = (gap_k_r == fill_r);
  // A new bar opens on the first popped trade, or as the last bar of a closing run is loaded.
  assign do_start = (pop && !bar_open_r) ||
                    (st_r == B_CLOSE && out_free && fill_r == '0) ||
                    (st_r == B_GAP && out_free && last_gap);
  assign div_start = (st_r == B_SUM);

  tca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (price_sum_r),
    .divisor  (cnt_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      bar_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gap_k_r     <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (pop && bar_open_r && !do_merge) st_r <= B_MUL0;
        end
        B_MUL0: st_r <= B_MUL1;
        B_MUL1: st_r <= B_SUM;
        B_SUM:  st_r <= B_DIV;
        B_DIV:  if (div_done) st_r <= B_CLOSE;
        B_CLOSE: begin
          if (out_free) begin
            gap_k_r     <= {{(FillW-1){1'b0}}, 1'b1};
            st_r        <= (fill_r == '0) ? B_IDLE : B_GAP;
          end
        end
        B_GAP: begin
          if (out_free) begin
            gap_k_r     <= gap_k_r + FillW'(1);
            if (last_gap) st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
      if (do_start) bar_open_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && bar_open_r && !do_merge) begin
      cur_r   <= head;
      fill_r  <= (gaps > 48'(MaxFill)) ? FillW'(MaxFill) : gaps[FillW-1:0];
      trunc_r <= gaps > 48'(MaxFill);
    end
    if (st_r == B_MUL0) p0_r <= {32'b0, idx1[31:0]} * {32'b0, iv};
    if (st_r == B_MUL1) p1_r <= {32'b0, idx1[48:32]} * {17'b0, iv};
    if (st_r == B_SUM)  end_r <= p0_r[48:0] + {p1_r[16:0], 32'b0};
    if (st_r == B_DIV && div_done) begin
      if (cnt_sum == '0) avg_r <= '0;
      else if (div_q[63:32] != '0) avg_r <= {32{1'b1}};
      else avg_r <= div_q[31:0];
    end
    if (st_r == B_CLOSE && out_free) begin
      out_r <= '{bar_end_time: end_r, bar_high: run_high_r, bar_avg: avg_r,
                 bar_low: run_low_r, buy_volume: buy_vol_r, sell_volume: sell_vol_r,
                 buy_trades: buy_cnt_r, sell_trades: sell_cnt_r, is_gap_bar: 1'b0,
                 gap_truncated: trunc_r, last_of_run: (fill_r == '0)};
      end_r <= end_r + {17'b0, iv};
    end
    if (st_r == B_GAP && out_free) begin
      out_r <= '{bar_end_time: end_r, bar_high: cur_r.price, bar_avg: cur_r.price,
                 bar_low: cur_r.price, buy_volume: '0, sell_volume: '0,
                 buy_trades: '0, sell_trades: '0, is_gap_bar: 1'b1,
                 gap_truncated: trunc_r, last_of_run: last_gap};
      end_r <= end_r + {17'b0, iv};
    end
    if (do_merge) begin
      if (head.price > run_high_r) run_high_r <= head.price;
      if (head.price < run_low_r)  run_low_r  <= head.price;
      price_sum_r <= sat_add64(price_sum_r, {32'b0, head.price});
      if (head.sell) begin
        sell_vol_r <= sat_add64(sell_vol_r, head.vol);
        sell_cnt_r <= sat_inc32(sell_cnt_r);
      end else begin
        buy_vol_r <= sat_add64(buy_vol_r, head.vol);
        buy_cnt_r <= sat_inc32(buy_cnt_r);
      end
    end else if (do_start) begin
      // The opening trade is the queue head on first use, else the held one.
      bar_index_r <= bar_open_r ? cur_r.idx : head.idx;
      run_high_r  <= bar_open_r ? cur_r.price : head.price;
      run_low_r   <= bar_open_r ? cur_r.price : head.price;
      price_sum_r <= {32'b0, (bar_open_r ? cur_r.price : head.price)};
      buy_vol_r   <= (bar_open_r ? cur_r.sell : head.sell) ? '0
                     : (bar_open_r ? cur_r.vol : head.vol);
      sell_vol_r  <= (bar_open_r ? cur_r.sell : head.sell)
                     ? (bar_open_r ? cur_r.vol : head.vol) : '0;
      buy_cnt_r   <= {31'b0, !(bar_open_r ? cur_r.sell : head.sell)};
      sell_cnt_r  <= {31'b0, (bar_open_r ? cur_r.sell : head.sell)};
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.bar_end_time  = out_r.bar_end_time;
  assign out_ch.bar_high      = out_r.bar_high;
  assign out_ch.bar_avg       = out_r.bar_avg;
  assign out_ch.bar_low       = out_r.bar_low;
  assign out_ch.buy_volume    = out_r.buy_volume;
  assign out_ch.sell_volume   = out_r.sell_volume;
  assign out_ch.buy_trades    = out_r.buy_trades;
  assign out_ch.sell_trades   = out_r.sell_trades;
  assign out_ch.is_gap_bar    = out_r.is_gap_bar;
  assign out_ch.gap_truncated = out_r.gap_truncated;
  assign out_ch.last_of_run   = out_r.last_of_run;

`ifndef SYNTHESIS
  a_open_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    bar_open_r |=> bar_open_r) else $error("open bar was dropped");
  a_gap_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_GAP) |-> (gap_k_r != '0 && gap_k_r <= fill_r))
    else $error("gap counter out of range");
  a_close_needs_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_MUL0) |-> (bar_open_r && cnt_sum != '0))
    else $error("close started without an open bar");
`endif

endmodule

FILE: hdl/trade_candle_aggregator_unit.sv
// ----------------------------------------------------------------------------
// trade_candle_aggregator_unit
// OHLC bar aggregation over a trade stream, with gap bars between trades.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  in_ch    sink       one trade per item
//  out_ch   source     one closed or gap bar per item
//  cfg_ch   sink       bar_interval write, always ready
//
// The front accepts a trade only when idle, after its index divide and push.
// A closing trade takes the back through the end-time products, then the
// bit-serial average divide, then emits its bars; merges are done on pop.
// A two-entry queue lets the front run ahead while the back emits bars.
// Reset (rst_n low, synchronous) closes the bar and sets the interval to 1000.
// ----------------------------------------------------------------------------
module trade_candle_aggregator_unit (
  input  logic      clk,
  input  logic      rst_n,
  tca_in_if.sink    in_ch,
  tca_out_if.source out_ch,
  tca_cfg_if.sink   cfg_ch
);
  import tca_pkg::*;

  logic [31:0] interval_r;
  logic [31:0] iv;
  logic        push;
  logic        pop;
  trade_item_t push_item;
  trade_item_t head;
  q_status_t   q_stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IntervalReset;
    end else if (cfg_ch.valid) begin
      interval_r <= cfg_ch.bar_interval;
    end
  end

  // A zero interval behaves as one.
  assign iv = (interval_r == '0) ? 32'd1 : interval_r;

  tca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .iv        (iv),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  tca_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  tca_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .iv     (iv),
    .out_ch (out_ch)
  );

endmodule
